// ===== sv/vat_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vat_pkg
// Shared types and constants of the vertex affine transform.
// ----------------------------------------------------------------------------
package vat_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int FIELD_W     = 32;
    localparam int NUM_LANES   = 3;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 104;

    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_REGS  = 6;
    localparam int HALF_W    = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_COEF_A = 3'd0,
        REG_X_COEF_B = 3'd1,
        REG_Y_COEF_A = 3'd2,
        REG_Y_COEF_B = 3'd3,
        REG_Z_COEF_A = 3'd4,
        REG_Z_COEF_B = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic s1_en;
        logic s2_en;
        logic s3_en;
        logic s4_en;
    } stage_en_t;

endpackage
`default_nettype wire

// ===== sv/vat_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vat_lane
// One output component: three products, translation, round, saturate.
// ----------------------------------------------------------------------------
module vat_lane #(
    parameter int COORD_WIDTH = vat_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = vat_pkg::FRAC_BITS_DEF
) (
    input  wire                                clk,
    input  wire vat_pkg::stage_en_t            en,
    input  wire logic signed [COORD_WIDTH-1:0] x,
    input  wire logic signed [COORD_WIDTH-1:0] y,
    input  wire logic signed [COORD_WIDTH-1:0] z,
    input  wire logic [vat_pkg::CFG_W-1:0]     coef_a,
    input  wire logic [vat_pkg::CFG_W-1:0]     coef_b,
    output logic [COORD_WIDTH-1:0]             comp,
    output logic                               clip
);

    localparam int PROD_W = 2 * COORD_WIDTH;
    localparam int BASE_W = (PROD_W > COORD_WIDTH + FRAC_BITS) ? PROD_W
                                                               : COORD_WIDTH + FRAC_BITS;
    localparam int ACC_W  = BASE_W + 2;
    localparam int R_W    = ACC_W - FRAC_BITS;

    localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [R_W-1:0]   MAXV = R_W'((64'(1) << (COORD_WIDTH - 1)) - 64'(1));
    localparam logic signed [R_W-1:0]   MINV = ~MAXV;

    logic signed [COORD_WIDTH-1:0] c0, c1, c2, t;
    logic signed [PROD_W-1:0]      p0_reg, p1_reg, p2_reg;
    logic signed [ACC_W-1:0]       sum01_reg, sum2t_reg, total_reg;
    logic signed [ACC_W-1:0]       sum01_next, sum2t_next;
    logic signed [R_W-1:0]         r;
    logic [COORD_WIDTH-1:0]        comp_reg, comp_next;
    logic                          clip_reg, clip_next;

    assign c0 = coef_a[COORD_WIDTH-1:0];
    assign c1 = coef_a[vat_pkg::HALF_W+COORD_WIDTH-1:vat_pkg::HALF_W];
    assign c2 = coef_b[COORD_WIDTH-1:0];
    assign t  = coef_b[vat_pkg::HALF_W+COORD_WIDTH-1:vat_pkg::HALF_W];

    always_comb
    begin
        sum01_next = ACC_W'(p0_reg) + ACC_W'(p1_reg);
        sum2t_next = ACC_W'(p2_reg) + (ACC_W'(t) <<< FRAC_BITS) + RND;
    end

    always_comb
    begin
        r = R_W'(total_reg >>> FRAC_BITS);
        priority if (r > MAXV)
        begin
            comp_next = MAXV[COORD_WIDTH-1:0];
            clip_next = 1'b1;
        end
        else if (r < MINV)
        begin
            comp_next = MINV[COORD_WIDTH-1:0];
            clip_next = 1'b1;
        end
        else
        begin
            comp_next = r[COORD_WIDTH-1:0];
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1_en)
        begin
            p0_reg <= c0 * x;
            p1_reg <= c1 * y;
            p2_reg <= c2 * z;
        end
        if (en.s2_en)
        begin
            sum01_reg <= sum01_next;
            sum2t_reg <= sum2t_next;
        end
        if (en.s3_en)
        begin
            total_reg <= sum01_reg + sum2t_reg;
        end
        if (en.s4_en)
        begin
            comp_reg <= comp_next;
            clip_reg <= clip_next;
        end
    end

    assign comp = comp_reg;
    assign clip = clip_reg;

endmodule
`default_nettype wire

// ===== sv/vat_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vat_merge
// Output register: packs the three lane results and joins their clip flags.
// ----------------------------------------------------------------------------
module vat_merge #(
    parameter int COORD_WIDTH = vat_pkg::COORD_WIDTH_DEF
) (
    input  wire                                            clk,
    input  wire                                            load,
    input  wire logic [vat_pkg::NUM_LANES-1:0][COORD_WIDTH-1:0] comp,
    input  wire logic [vat_pkg::NUM_LANES-1:0]             clip,
    output logic [vat_pkg::OUT_TDATA_W-1:0]                tdata
);

    logic [vat_pkg::OUT_TDATA_W-1:0] tdata_reg, tdata_next;
    logic [vat_pkg::FIELD_W-1:0]     fx, fy, fz;

    always_comb
    begin
        fx = vat_pkg::FIELD_W'($signed(comp[0]));
        fy = vat_pkg::FIELD_W'($signed(comp[1]));
        fz = vat_pkg::FIELD_W'($signed(comp[2]));
        tdata_next = vat_pkg::OUT_TDATA_W'({|clip, fz, fy, fx});
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tdata_reg <= tdata_next;
        end
    end

    assign tdata = tdata_reg;

endmodule
`default_nettype wire

// ===== sv/vertex_affine_transform_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_affine_transform_top
// Affine 4x3 transform of Q16.16 vertices, three lanes, saturated output.
// ----------------------------------------------------------------------------
//  channel | dir | bits | contents (low bit up)
//  s_axis  | in  | 96   | s_tdata: in_x, in_y, in_z
//  m_axis  | out | 104  | m_tdata: out_x, out_y, out_z, saturated, zero pad
//  cfg     | in  | 64   | cfg_we, cfg_index, cfg_data (six coefficient pairs)
//
//  One item per cycle while m_axis is not stalled; an accepted item passes
//  five registers in order: multiply, two add stages, round/saturate, output.
//  Reset: coefficients go to identity, pipeline empties.
//  A stage holds only when the stage after it is full and stalled, so
//  bubbles collapse and input is taken while a result waits.
// ----------------------------------------------------------------------------
module vertex_affine_transform_top #(
    parameter int COORD_WIDTH = vat_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = vat_pkg::FRAC_BITS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire logic [vat_pkg::IN_TDATA_W-1:0] s_tdata,   // in_x, in_y, in_z
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [vat_pkg::OUT_TDATA_W-1:0]     m_tdata,   // out_x, out_y, out_z, saturated
    input  wire                                 cfg_we,
    input  wire logic [vat_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [vat_pkg::CFG_W-1:0]      cfg_data
);

    localparam logic [vat_pkg::CFG_W-1:0] COEF_ONE = vat_pkg::CFG_W'(1) << FRAC_BITS;
    localparam int NSTG = 4;

    logic [vat_pkg::CFG_W-1:0] coef_reg [vat_pkg::NUM_REGS];

    logic [NSTG-1:0] v_reg, v_next;
    logic            out_valid_reg, out_valid_next;
    logic [NSTG:0]   en;
    vat_pkg::stage_en_t stage_en;

    logic signed [COORD_WIDTH-1:0] x, y, z;
    logic [vat_pkg::NUM_LANES-1:0][COORD_WIDTH-1:0] comp;
    logic [vat_pkg::NUM_LANES-1:0] clip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[vat_pkg::REG_X_COEF_A] <= COEF_ONE;
            coef_reg[vat_pkg::REG_X_COEF_B] <= '0;
            coef_reg[vat_pkg::REG_Y_COEF_A] <= COEF_ONE << vat_pkg::HALF_W;
            coef_reg[vat_pkg::REG_Y_COEF_B] <= '0;
            coef_reg[vat_pkg::REG_Z_COEF_A] <= '0;
            coef_reg[vat_pkg::REG_Z_COEF_B] <= COEF_ONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vat_pkg::REG_X_COEF_A: coef_reg[vat_pkg::REG_X_COEF_A] <= cfg_data;
                vat_pkg::REG_X_COEF_B: coef_reg[vat_pkg::REG_X_COEF_B] <= cfg_data;
                vat_pkg::REG_Y_COEF_A: coef_reg[vat_pkg::REG_Y_COEF_A] <= cfg_data;
                vat_pkg::REG_Y_COEF_B: coef_reg[vat_pkg::REG_Y_COEF_B] <= cfg_data;
                vat_pkg::REG_Z_COEF_A: coef_reg[vat_pkg::REG_Z_COEF_A] <= cfg_data;
                vat_pkg::REG_Z_COEF_B: coef_reg[vat_pkg::REG_Z_COEF_B] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        en[NSTG] = !out_valid_reg || m_tready;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next[0] = en[0] ? s_tvalid : v_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
        out_valid_next = en[NSTG] ? v_reg[NSTG-1] : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v_reg         <= v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign stage_en.s1_en = en[0];
    assign stage_en.s2_en = en[1];
    assign stage_en.s3_en = en[2];
    assign stage_en.s4_en = en[3];

    assign x = s_tdata[COORD_WIDTH-1:0];
    assign y = s_tdata[vat_pkg::FIELD_W+COORD_WIDTH-1:vat_pkg::FIELD_W];
    assign z = s_tdata[2*vat_pkg::FIELD_W+COORD_WIDTH-1:2*vat_pkg::FIELD_W];

    for (genvar k = 0; k < vat_pkg::NUM_LANES; k++)
    begin : g_lane
        vat_lane #(
            .COORD_WIDTH (COORD_WIDTH),
            .FRAC_BITS   (FRAC_BITS)
        ) u_lane (
            .clk    (clk),
            .en     (stage_en),
            .x      (x),
            .y      (y),
            .z      (z),
            .coef_a (coef_reg[2*k]),
            .coef_b (coef_reg[2*k+1]),
            .comp   (comp[k]),
            .clip   (clip[k])
        );
    end

    vat_merge #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_merge (
        .clk   (clk),
        .load  (en[NSTG]),
        .comp  (comp),
        .clip  (clip),
        .tdata (m_tdata)
    );

    assign s_tready = en[0];
    assign m_tvalid = out_valid_reg;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output register");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v_reg[0])
        else $error("accepted item missing from first stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NSTG-1] && !en[NSTG] |=> v_reg[NSTG-1])
        else $error("stalled item lost from last lane stage");

    a_out_fed: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg && v_reg[NSTG-1] |=> out_valid_reg)
        else $error("finished item not moved to output register");

endmodule
`default_nettype wire
